[hw/rtl/delay_statistics_tracker_unit_defines.svh]
// Assertion macros shared by the delay statistics tracker RTL.
`ifndef DELAY_STATISTICS_TRACKER_UNIT_DEFINES_SVH
`define DELAY_STATISTICS_TRACKER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in the next cycle follows from a trigger.
`define DST_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DST_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/dst_pkg.sv]
// Package of types and constants for the delay statistics tracker.
package dst_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  localparam logic [15:0] EMA_GAIN_RST   = 16'd6554;
  localparam logic [15:0] CONF_FACT_RST  = 16'd435;

  localparam logic CFG_IDX_EMA_GAIN  = 1'b0;
  localparam logic CFG_IDX_CONF_FACT = 1'b1;

  typedef enum logic {
    ITU_DIV,
    ITU_SQRT
  } itu_op_e;

  typedef struct packed {
    logic    start;
    itu_op_e op;
  } itu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } itu_sts_t;

endpackage

[hw/rtl/delay_statistics_tracker_unit.sv]
// Delay statistics tracker top level: sequencer, window store and shared arithmetic.
// Each item returns the window minimum, the confidence upper bound, the mean, the variance
// and both counters. One item is taken at a time. The time to a result grows with the window
// fill, and is set by the bit-serial 64 step divide and the 32 step square root in the
// iterative unit, and by the window scan, which reads one entry of the window RAM per pass
// through a read state and a compare state. A flow item with an empty window skips the scan
// and the iterative unit and returns the mean as minimum and bound. The next item is taken
// as soon as the result is presented, even while that result still waits at the output
// register; a result that is stalled when the next one is ready holds the sequencer.
`include "delay_statistics_tracker_unit_defines.svh"

module delay_statistics_tracker_unit
  import dst_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] delay_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] best_delay_o,
  output logic [31:0] upper_bound_delay_o,
  output logic [31:0] mean_delay_o,
  output logic [47:0] delay_variance_o,
  output logic [31:0] samples_seen_o,
  output logic [31:0] flow_measure_o
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW = FW + 1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FLOW,
    ST_MEAN,
    ST_MEANUPD,
    ST_DEV,
    ST_SQ0,
    ST_SQ1,
    ST_VAR,
    ST_VARUPD,
    ST_SCAN0,
    ST_RD,
    ST_CMP,
    ST_DIVGO,
    ST_DIVW,
    ST_SQGO,
    ST_SQW,
    ST_TERM,
    ST_UB,
    ST_OUT
  } state_e;

  state_e        state_q;
  logic [15:0]   gain_q;
  logic [15:0]   conf_q;
  logic [31:0]   sample_q;
  logic [31:0]   mean_q;
  logic [47:0]   var_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] head_q;
  logic [31:0]   cnt_q;
  logic [31:0]   flow_q;
  logic [31:0]   dev_q;
  logic [63:0]   acc_q;
  logic [47:0]   sq_q;
  logic [31:0]   best_q;
  logic [31:0]   upper_q;
  logic [FW-1:0] idx_q;
  logic          out_valid_q;

  logic [47:0]   mul_a;
  logic [15:0]   mul_b;
  logic [63:0]   mul_p;
  logic [63:0]   rnd;
  logic [47:0]   step;
  logic          s_ge;
  logic [31:0]   s_diff;
  logic          v_ge;
  logic [47:0]   v_diff;
  logic [63:0]   sq_full;
  logic [SW-1:0] wsum;
  logic [SW-1:0] rsum;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          ram_we;
  logic [31:0]   ram_rdata;
  logic [48:0]   ub_sum;
  logic [SW-1:0] idx_nx;
  itu_cmd_t      itu_cmd;
  itu_sts_t      itu_sts;
  logic [63:0]   itu_a;
  logic [63:0]   itu_res;

  always_comb begin
    s_ge    = sample_q >= mean_q;
    s_diff  = s_ge ? (sample_q - mean_q) : (mean_q - sample_q);
    v_ge    = sq_q >= var_q;
    v_diff  = v_ge ? (sq_q - var_q) : (var_q - sq_q);
    rnd     = mul_p + 64'd32768;
    step    = rnd[63:16];
    sq_full = acc_q + {mul_p[47:0], 16'b0};
    ub_sum  = {17'b0, mean_q} + {1'b0, step};
    idx_nx  = {1'b0, idx_q} + SW'(1);

    wsum = {1'b0, head_q} + SW'(fill_q);
    if (wsum >= SW'(WINDOW_DEPTH)) begin
      wsum = wsum - SW'(WINDOW_DEPTH);
    end
    rsum = {1'b0, head_q} + SW'(idx_q);
    if (rsum >= SW'(WINDOW_DEPTH)) begin
      rsum = rsum - SW'(WINDOW_DEPTH);
    end
    waddr  = (SW'(fill_q) < SW'(WINDOW_DEPTH)) ? wsum[AW-1:0] : head_q;
    raddr  = rsum[AW-1:0];
    ram_we = (state_q == ST_VARUPD);

    mul_a = {16'b0, s_diff};
    mul_b = gain_q;
    case (state_q)
      ST_DEV:  mul_b = s_diff[15:0];
      ST_SQ0: begin
        mul_a = {16'b0, dev_q};
        mul_b = dev_q[31:16];
      end
      ST_VAR:  mul_a = v_diff;
      ST_TERM: begin
        mul_a = {16'b0, itu_res[31:0]};
        mul_b = conf_q;
      end
      default: mul_b = gain_q;
    endcase

    itu_cmd.start = (state_q == ST_DIVGO) || (state_q == ST_SQGO);
    itu_cmd.op    = (state_q == ST_SQGO) ? ITU_SQRT : ITU_DIV;
    itu_a         = (state_q == ST_SQGO) ? itu_res : {var_q, 16'b0};
  end

  dst_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dst_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_DEPTH)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (sample_q),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  dst_itu #(
    .DW (FW)
  ) u_itu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (itu_cmd),
    .a_i    (itu_a),
    .div_i  (fill_q),
    .sts_o  (itu_sts),
    .res_o  (itu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= EMA_GAIN_RST;
      conf_q      <= CONF_FACT_RST;
      mean_q      <= '0;
      var_q       <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      flow_q      <= 32'd1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_EMA_GAIN:  gain_q <= cfg_data_i;
          CFG_IDX_CONF_FACT: conf_q <= cfg_data_i;
          default:           gain_q <= gain_q;
        endcase
      end
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q <= delay_sample_i;
            state_q  <= action_i ? ST_FLOW : ST_MEAN;
          end
        end
        ST_FLOW: begin
          if (flow_q != '1) begin
            flow_q <= flow_q + 32'd1;
          end
          state_q <= ST_SCAN0;
        end
        ST_MEAN: begin
          if (cnt_q != '1) begin
            cnt_q <= cnt_q + 32'd1;
          end
          if (mean_q == '0) begin
            mean_q  <= sample_q;
            state_q <= ST_DEV;
          end else begin
            state_q <= ST_MEANUPD;
          end
        end
        ST_MEANUPD: begin
          mean_q  <= s_ge ? (mean_q + step[31:0]) : (mean_q - step[31:0]);
          state_q <= ST_DEV;
        end
        ST_DEV: begin
          dev_q   <= s_diff;
          state_q <= ST_SQ0;
        end
        ST_SQ0: begin
          acc_q   <= mul_p;
          state_q <= ST_SQ1;
        end
        ST_SQ1: begin
          sq_q    <= (sq_full[63:48] != '0) ? '1 : sq_full[47:0];
          state_q <= ST_VAR;
        end
        ST_VAR: begin
          state_q <= ST_VARUPD;
        end
        ST_VARUPD: begin
          var_q <= v_ge ? (var_q + step) : (var_q - step);
          if (SW'(fill_q) < SW'(WINDOW_DEPTH)) begin
            fill_q <= fill_q + FW'(1);
          end else if (SW'(head_q) == SW'(WINDOW_DEPTH - 1)) begin
            head_q <= '0;
          end else begin
            head_q <= head_q + AW'(1);
          end
          state_q <= ST_SCAN0;
        end
        ST_SCAN0: begin
          idx_q <= '0;
          if (fill_q == '0) begin
            best_q  <= mean_q;
            upper_q <= mean_q;
            state_q <= ST_OUT;
          end else begin
            best_q  <= '1;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (ram_rdata < best_q) begin
            best_q <= ram_rdata;
          end
          idx_q   <= idx_nx[FW-1:0];
          state_q <= (idx_nx == SW'(fill_q)) ? ST_DIVGO : ST_RD;
        end
        ST_DIVGO: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (itu_sts.done) begin
            state_q <= ST_SQGO;
          end
        end
        ST_SQGO: begin
          state_q <= ST_SQW;
        end
        ST_SQW: begin
          if (itu_sts.done) begin
            state_q <= ST_TERM;
          end
        end
        ST_TERM: begin
          state_q <= ST_UB;
        end
        ST_UB: begin
          upper_q <= (ub_sum[48:32] != '0) ? '1 : ub_sum[31:0];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            best_delay_o        <= best_q;
            upper_bound_delay_o <= upper_q;
            mean_delay_o        <= mean_q;
            delay_variance_o    <= var_q;
            samples_seen_o      <= cnt_q;
            flow_measure_o      <= flow_q;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `DST_ASSERT(a_fill_bound, SW'(fill_q) <= SW'(WINDOW_DEPTH), "window fill above depth")
  `DST_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o && !action_i, state_q == ST_MEAN, "sample item not started")
  `DST_ASSERT(a_itu_done_wait, itu_sts.done |-> (state_q == ST_DIVW || state_q == ST_SQW), "iterative unit done outside wait")

endmodule

[hw/rtl/dst_ram.sv]
// Generic single write port, single read port RAM with registered read.
module dst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/dst_mul.sv]
// Shared 48 by 16 bit multiplier with registered product.
module dst_mul (
  input  logic        clk_i,
  input  logic [47:0] a_i,
  input  logic [15:0] b_i,
  output logic [63:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

[hw/rtl/dst_itu.sv]
// Iterative unit: bit-serial 64 bit divide by a small count, or 64 bit square root.
module dst_itu
  import dst_pkg::*;
#(
  parameter int unsigned DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itu_cmd_t      cmd_i,
  input  logic [63:0]   a_i,
  input  logic [DW-1:0] div_i,
  output itu_sts_t      sts_o,
  output logic [63:0]   res_o
);

  localparam int unsigned RW = (DW + 1 > 34) ? DW + 1 : 34;

  logic          busy_q;
  logic          done_q;
  itu_op_e       op_q;
  logic [5:0]    cnt_q;
  logic [63:0]   quo_q;
  logic [RW-1:0] rem_q;
  logic [31:0]   root_q;
  logic [DW-1:0] div_q;

  logic [RW-1:0] dr2;
  logic          dge;
  logic [RW+1:0] sr2;
  logic [RW+1:0] strial;
  logic          sge;

  always_comb begin
    dr2    = {rem_q[RW-2:0], quo_q[63]};
    dge    = dr2 >= RW'(div_q);
    sr2    = {rem_q, quo_q[63:62]};
    strial = (RW+2)'({root_q, 2'b01});
    sge    = sr2 >= strial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ITU_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= (cmd_i.op == ITU_DIV) ? 6'd63 : 6'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q  <= a_i;
      rem_q  <= '0;
      root_q <= '0;
      div_q  <= div_i;
    end else if (busy_q) begin
      case (op_q)
        ITU_DIV: begin
          rem_q <= dge ? (dr2 - RW'(div_q)) : dr2;
          quo_q <= {quo_q[62:0], dge};
        end
        ITU_SQRT: begin
          rem_q  <= sge ? RW'(sr2 - strial) : RW'(sr2);
          root_q <= {root_q[30:0], sge};
          quo_q  <= {quo_q[61:0], 2'b00};
        end
        default: begin
          quo_q <= quo_q;
        end
      endcase
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = (op_q == ITU_DIV) ? quo_q : {32'b0, root_q};

endmodule
